>>> sv/smpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpl_pkg
// Shared types and constants of the sorted minimum priority list.
// ----------------------------------------------------------------------------
package smpl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AddrW    = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned EntryW   = 32;

  typedef enum logic [0:0] {
    ReqInsert = 1'b0,
    ReqRemove = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrFull  = 2'd1,
    ErrEmpty = 2'd2
  } error_code_e;

  typedef enum logic [2:0] {
    StIdle,
    StInsRd,
    StInsSh,
    StInsWr,
    StRemRd,
    StRemHd,
    StScan
  } state_e;

  typedef struct packed {
    logic [15:0] idx;
    logic [15:0] key;
  } entry_t;

  typedef struct packed {
    req_type_e   req_type;
    logic [15:0] entry_index;
    logic [15:0] distance_key;
  } req_t;

  typedef struct packed {
    logic [15:0] head_index;
    logic [15:0] head_key;
    logic [6:0]  min_tie_count;
    logic [6:0]  entry_count;
    logic        is_empty;
    error_code_e error_code;
  } res_t;

endpackage
`default_nettype wire

>>> sv/smpl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smpl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/sorted_min_priority_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_list
// Bounded priority list kept in key order in a circular RAM buffer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// res_o for exactly one cycle with res_valid_o, and the receiver cannot stall
// it. Entries sit in ascending key order in one RAM used as a circular buffer,
// so a remove only moves the head pointer. An insert walks from the tail
// toward the head, one RAM read and one write per cycle, moving every entry
// whose key is not below the new key. An insert into an empty list goes straight
// to writing the new entry. A remove that leaves entries reads the new head and
// finishes there while the old run of equal minimum keys goes on; when that
// run is used up it scans the new run entry by entry to count its ties.
// Errors and a remove that empties the list finish straight from idle and
// never raise busy. Busy falls at the same edge that puts the result out.
// ----------------------------------------------------------------------------
module sorted_min_priority_list
  import smpl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output      logic busy,
  input  wire req_t req_i,
  output      logic res_valid_o,
  output      res_t res_o
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  ties_q, ties_d;
  logic [AddrW-1:0] hd_q, hd_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  entry_t           head_q, head_d;
  entry_t           new_q, new_d;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             accept;
  logic             fin;
  error_code_e      err;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           rdata;
  logic             key_lt;
  logic             key_eq;
  logic             scan_more;
  logic             full;
  logic [AddrW:0]   hd_inc;

  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] hd,
                                            input logic [AddrW-1:0] lg);
    logic [AddrW:0] s;
    s = {1'b0, hd} + {1'b0, lg};
    if (s >= (AddrW+1)'(CAPACITY)) begin
      s = s - (AddrW+1)'(CAPACITY);
    end
    return s[AddrW-1:0];
  endfunction

  smpl_ram #(
    .WIDTH (EntryW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign busy      = (state_q != StIdle);
  assign accept    = start && !busy;
  assign key_lt    = rdata.key < new_q.key;
  assign key_eq    = rdata.key == head_q.key;
  assign scan_more = (CntW'(ptr_q) + CntW'(1)) < cnt_q;
  assign full      = (cnt_q == CntW'(CAPACITY));
  assign hd_inc    = {1'b0, hd_q} + (AddrW+1)'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.req_type == ReqInsert) begin
            if (!full) begin
              state_d = (cnt_q == '0) ? StInsWr : StInsRd;
            end
          end else if (cnt_q > CntW'(1)) begin
            state_d = StRemRd;
          end
        end
      end
      StInsRd: state_d = StInsSh;
      StInsSh: begin
        if (!key_lt) begin
          state_d = (ptr_q == AddrW'(1)) ? StInsWr : StInsSh;
        end else begin
          state_d = StIdle;
        end
      end
      StInsWr: state_d = StIdle;
      StRemRd: state_d = StRemHd;
      StRemHd: begin
        if (ties_q > CntW'(1) || cnt_q == CntW'(1)) begin
          state_d = StIdle;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (key_eq && scan_more) begin
          state_d = StScan;
        end else begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cnt_d     = cnt_q;
    ties_d    = ties_q;
    hd_d      = hd_q;
    ptr_d     = ptr_q;
    head_d    = head_q;
    new_d     = new_q;
    fin       = 1'b0;
    err       = ErrNone;
    ram_we    = 1'b0;
    ram_waddr = phys(hd_q, ptr_q);
    ram_wdata = rdata;
    ram_raddr = phys(hd_q, ptr_q);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.req_type == ReqInsert) begin
            if (full) begin
              fin = 1'b1;
              err = ErrFull;
            end else begin
              new_d.idx = req_i.entry_index;
              new_d.key = req_i.distance_key;
              ptr_d     = cnt_q[AddrW-1:0];
              cnt_d     = cnt_q + CntW'(1);
              if (cnt_q == '0 || req_i.distance_key < head_q.key) begin
                head_d.idx = req_i.entry_index;
                head_d.key = req_i.distance_key;
                ties_d     = CntW'(1);
              end else if (req_i.distance_key == head_q.key) begin
                head_d.idx = req_i.entry_index;
                head_d.key = req_i.distance_key;
                ties_d     = ties_q + CntW'(1);
              end
            end
          end else begin
            if (cnt_q == '0) begin
              fin = 1'b1;
              err = ErrEmpty;
            end else begin
              cnt_d = cnt_q - CntW'(1);
              hd_d  = (hd_inc == (AddrW+1)'(CAPACITY)) ? '0 : hd_inc[AddrW-1:0];
              ptr_d = '0;
              if (cnt_q == CntW'(1)) begin
                head_d = '0;
                ties_d = '0;
                fin    = 1'b1;
              end
            end
          end
        end
      end
      StInsRd: begin
        ram_raddr = phys(hd_q, ptr_q - AddrW'(1));
      end
      StInsSh: begin
        ram_we = 1'b1;
        if (!key_lt) begin
          ram_wdata = rdata;
          ram_raddr = phys(hd_q, ptr_q - AddrW'(2));
          ptr_d     = ptr_q - AddrW'(1);
        end else begin
          ram_wdata = new_q;
          fin       = 1'b1;
        end
      end
      StInsWr: begin
        ram_we    = 1'b1;
        ram_wdata = new_q;
        fin       = 1'b1;
      end
      StRemRd: begin
        ram_raddr = phys(hd_q, '0);
      end
      StRemHd: begin
        head_d = rdata;
        if (ties_q > CntW'(1)) begin
          ties_d = ties_q - CntW'(1);
          fin    = 1'b1;
        end else begin
          ties_d = CntW'(1);
          if (cnt_q == CntW'(1)) begin
            fin = 1'b1;
          end else begin
            ptr_d     = AddrW'(1);
            ram_raddr = phys(hd_q, AddrW'(1));
          end
        end
      end
      StScan: begin
        if (key_eq) begin
          ties_d = ties_q + CntW'(1);
          if (scan_more) begin
            ptr_d     = ptr_q + AddrW'(1);
            ram_raddr = phys(hd_q, ptr_q + AddrW'(1));
          end else begin
            fin = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    res_valid_d = fin;
    res_d       = res_q;
    if (fin) begin
      res_d.head_index    = head_d.idx;
      res_d.head_key      = head_d.key;
      res_d.min_tie_count = 7'(ties_d);
      res_d.entry_count   = 7'(cnt_d);
      res_d.is_empty      = (cnt_d == '0);
      res_d.error_code    = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ties_q      <= '0;
      hd_q        <= '0;
      ptr_q       <= '0;
      head_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ties_q      <= ties_d;
      hd_q        <= hd_d;
      ptr_q       <= ptr_d;
      head_q      <= head_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

>>> tb/sorted_min_priority_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_min_priority_list_tb
// Self-checking bench: a tracker mirrors the sorted table for every accepted
// request and compares each result field by field. Directed requests cover
// extremes, key ties and the empty-list error. Random traffic then runs fill and
// drain phases that reach full and empty repeatedly, with random start gaps.
// ----------------------------------------------------------------------------
module sorted_min_priority_list_tb;
  import smpl_pkg::*;

  class min_list_tracker;
    entry_t      slots[CAPACITY];
    int unsigned held = 0;
    res_t        pending_heads[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    function string describe(res_t r);
      return $sformatf("idx %h key %h ties %0d count %0d empty %0b err %0d",
                       r.head_index, r.head_key, r.min_tie_count, r.entry_count,
                       r.is_empty, r.error_code);
    endfunction

    function void note_request(req_t r);
      res_t        head;
      int unsigned pos;
      int unsigned ties;
      head = '0;
      head.error_code = ErrNone;
      if (r.req_type == ReqInsert) begin
        if (held >= CAPACITY) begin
          head.error_code = ErrFull;
        end else begin
          pos = 0;
          while (pos < held && slots[pos].key < r.distance_key) pos++;
          for (int j = held; j > int'(pos); j--) slots[j] = slots[j-1];
          slots[pos].idx = r.entry_index;
          slots[pos].key = r.distance_key;
          held++;
        end
      end else begin
        if (held == 0) begin
          head.error_code = ErrEmpty;
        end else begin
          for (int j = 1; j < int'(held); j++) slots[j-1] = slots[j];
          held--;
        end
      end
      ties = 0;
      if (held > 0) begin
        head.head_index = slots[0].idx;
        head.head_key   = slots[0].key;
        while (ties < held && slots[ties].key == slots[0].key) ties++;
      end
      head.min_tie_count = 7'(ties);
      head.entry_count   = 7'(held);
      head.is_empty      = (held == 0);
      pending_heads.push_back(head);
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (pending_heads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d unexpected: got %s", results_seen, describe(got));
        return;
      end
      want = pending_heads.pop_front();
      if (got.head_index !== want.head_index || got.head_key !== want.head_key ||
          got.min_tie_count !== want.min_tie_count ||
          got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
          got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected %s, got %s", results_seen, describe(want),
                   describe(got));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  min_list_tracker tracker = new();
  bit              allow_idle = 1'b1;
  int unsigned     fill_level = 0;

  sorted_min_priority_list dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("sorted_min_priority_list: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) tracker.note_request(req_i);
      if (res_valid_o) tracker.check_result(res_o);
    end
  end

  task automatic send_request(req_type_e kind, logic [15:0] idx, logic [15:0] key);
    @(negedge clk_i);
    if (allow_idle) begin
      while ($urandom_range(0, 99) < 22) begin
        start = 1'b0;
        @(negedge clk_i);
      end
    end
    start              = 1'b1;
    req_i.req_type     = kind;
    req_i.entry_index  = idx;
    req_i.distance_key = key;
    do @(posedge clk_i); while (busy);
    if (kind == ReqInsert && fill_level < CAPACITY) fill_level++;
    else if (kind == ReqRemove && fill_level > 0) fill_level--;
  endtask

  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2, 3, 4: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    bit          filling;
    bit          do_insert;
    int unsigned bias;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, ties with newest first, the empty-list error
    send_request(ReqRemove, 16'hffff, 16'hffff);
    send_request(ReqInsert, 16'h0000, 16'h0000);
    send_request(ReqInsert, 16'hffff, 16'hffff);
    send_request(ReqInsert, 16'h0001, 16'h0010);
    send_request(ReqInsert, 16'h0002, 16'h0010);
    send_request(ReqInsert, 16'h0003, 16'h0000);
    send_request(ReqInsert, 16'h0004, 16'hffff);
    repeat (6) send_request(ReqRemove, 16'hffff, 16'hffff);
    send_request(ReqRemove, 16'h0000, 16'h0000);
    send_request(ReqInsert, 16'haaaa, 16'h5555);
    send_request(ReqInsert, 16'h5555, 16'haaaa);
    send_request(ReqRemove, 16'h5555, 16'h5555);
    send_request(ReqRemove, 16'haaaa, 16'haaaa);
    send_request(ReqRemove, 16'h1234, 16'h4321);

    // fill and drain phases reaching full and empty over and over
    filling = 1'b1;
    bias    = 85;
    for (int n = 0; n < 950; n++) begin
      allow_idle = !(n >= 400 && n < 650);
      if (filling && fill_level == CAPACITY && $urandom_range(0, 3) == 0) begin
        filling = 1'b0;
        bias    = $urandom_range(55, 95);
      end else if (!filling && fill_level == 0 && $urandom_range(0, 3) == 0) begin
        filling = 1'b1;
        bias    = $urandom_range(55, 95);
      end
      do_insert = filling ? ($urandom_range(1, 100) <= bias)
                          : ($urandom_range(1, 100) > bias);
      send_request(do_insert ? ReqInsert : ReqRemove, 16'($urandom_range(0, 65535)),
                   pick_key());
    end

    @(negedge clk_i);
    start = 1'b0;
    while (tracker.pending_heads.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_heads.size() == 0) begin
      $display("sorted_min_priority_list: match");
    end else begin
      $display("sorted_min_priority_list: mismatch");
    end
    $finish;
  end

endmodule
